@@ rtl/core/bsbc_pkg.sv @@
`default_nettype none

package bsbc_pkg;

  localparam int unsigned MAX_PARITY_BITS_DEF = 192;
  localparam int unsigned GEN_BITS = 192;
  localparam int unsigned COEF_SLOTS = 224;
  localparam int unsigned POLY_BITS = 17;
  localparam int unsigned MODE_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_N8     = 3'd0,
    MODE_N10    = 3'd1,
    MODE_N12    = 3'd2,
    MODE_SHORT  = 3'd3,
    MODE_MEDIUM = 3'd4
  } code_mode_e;

  typedef enum logic {
    REG_CODE_MODE = 1'b0,
    REG_UNUSED    = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic advance;
    logic last;
  } rem_ctrl_t;

  // Minimal polynomials, bit i is the coefficient of x^i.
  // Row 0 normal frames, row 1 short frames, row 2 medium frames.
  localparam logic [POLY_BITS-1:0] MIN_POLY [3][12] = '{
    '{17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
      17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3},
    '{17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
      17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF},
    '{17'h0802D, 17'h08C93, 17'h0B555, 17'h08D6D, 17'h094D7, 17'h0B0D1,
      17'h0D8B5, 17'h0CB55, 17'h0BAB7, 17'h0BC9F, 17'h08A17, 17'h0ED15}
  };

  function automatic int unsigned mode_width(input code_mode_e m);
    int unsigned w;
    unique case (m)
      MODE_N8:     w = 128;
      MODE_N10:    w = 160;
      MODE_N12:    w = 192;
      MODE_SHORT:  w = 168;
      MODE_MEDIUM: w = 180;
      default:     w = 192;
    endcase
    return w;
  endfunction

  function automatic code_mode_e active_mode(input logic [MODE_BITS-1:0] raw,
                                             input int unsigned max_bits);
    code_mode_e m;
    unique case (code_mode_e'(raw))
      MODE_N8, MODE_N10, MODE_N12, MODE_SHORT, MODE_MEDIUM: m = code_mode_e'(raw);
      default: m = MODE_N12;
    endcase
    if (mode_width(m) > max_bits) begin
      m = MODE_N8;
    end
    return m;
  endfunction

  // Generator without its leading term, left-justified in GEN_BITS bits.
  function automatic logic [GEN_BITS-1:0] gen_poly(input code_mode_e m);
    logic [COEF_SLOTS-1:0] acc;
    logic [COEF_SLOTS-1:0] tmp;
    logic [GEN_BITS-1:0] g;
    int fam;
    int cnt;
    int w;
    unique case (m)
      MODE_N8:     begin fam = 0; cnt = 8;  end
      MODE_N10:    begin fam = 0; cnt = 10; end
      MODE_SHORT:  begin fam = 1; cnt = 12; end
      MODE_MEDIUM: begin fam = 2; cnt = 12; end
      default:     begin fam = 0; cnt = 12; end
    endcase
    w = int'(mode_width(m));
    acc = COEF_SLOTS'(1);
    for (int p = 0; p < cnt; p++) begin
      tmp = '0;
      for (int j = 0; j < POLY_BITS; j++) begin
        if (MIN_POLY[fam][p][j]) begin
          tmp = tmp ^ (acc << j);
        end
      end
      acc = tmp;
    end
    g = '0;
    for (int k = 0; k < w; k++) begin
      g[GEN_BITS-1-k] = acc[w-1-k];
    end
    return g;
  endfunction

  localparam logic [GEN_BITS-1:0] GEN_N8     = gen_poly(MODE_N8);
  localparam logic [GEN_BITS-1:0] GEN_N10    = gen_poly(MODE_N10);
  localparam logic [GEN_BITS-1:0] GEN_N12    = gen_poly(MODE_N12);
  localparam logic [GEN_BITS-1:0] GEN_SHORT  = gen_poly(MODE_SHORT);
  localparam logic [GEN_BITS-1:0] GEN_MEDIUM = gen_poly(MODE_MEDIUM);

endpackage

`default_nettype wire

@@ rtl/core/bsbc_cfg.sv @@
`default_nettype none

module bsbc_cfg
  import bsbc_pkg::*;
#(
  parameter int unsigned MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output code_mode_e                    mode_o
);

  logic [MODE_BITS-1:0] code_mode_q;
  logic [MODE_BITS-1:0] code_mode_d;
  reg_index_e           reg_idx;

  assign reg_idx = reg_index_e'(paddr[APB_ADDR_BITS-1]);
  assign pready  = 1'b1;

  always_comb begin
    code_mode_d = code_mode_q;
    if (psel && penable && pwrite && (reg_idx == REG_CODE_MODE)) begin
      code_mode_d = pwdata[MODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_mode_q <= MODE_N12;
    end else begin
      code_mode_q <= code_mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CODE_MODE) begin
      prdata = {{(APB_DATA_BITS-MODE_BITS){1'b0}}, code_mode_q};
    end
  end

  assign mode_o = active_mode(code_mode_q, MAX_PARITY_BITS);

endmodule

`default_nettype wire

@@ rtl/core/bsbc_rem.sv @@
`default_nettype none

module bsbc_rem
  import bsbc_pkg::*;
#(
  parameter int unsigned MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rem_ctrl_t  ctrl_i,
  input  wire logic [7:0] data_byte_i,
  input  wire code_mode_e mode_i,
  output logic            parity_error_o,
  output logic            rem_zero_o
);

  localparam int unsigned REG_BITS = ((MAX_PARITY_BITS + 63) / 64) * 64;

  logic [REG_BITS-1:0] rem_q;
  logic [REG_BITS-1:0] rem_d;
  logic [GEN_BITS-1:0] gen_full;
  logic [REG_BITS-1:0] gen;
  logic [REG_BITS-1:0] acc;

  always_comb begin
    unique case (mode_i)
      MODE_N8:     gen_full = GEN_N8;
      MODE_N10:    gen_full = GEN_N10;
      MODE_N12:    gen_full = GEN_N12;
      MODE_SHORT:  gen_full = GEN_SHORT;
      MODE_MEDIUM: gen_full = GEN_MEDIUM;
      default:     gen_full = GEN_N12;
    endcase
  end

  assign gen = gen_full[GEN_BITS-1 -: REG_BITS];

  // Eight steps of bitwise long division, most significant data bit first.
  always_comb begin
    acc = rem_q;
    for (int b = 7; b >= 0; b--) begin
      if (acc[REG_BITS-1] ^ data_byte_i[b]) begin
        acc = (acc << 1) ^ gen;
      end else begin
        acc = acc << 1;
      end
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.advance) begin
      rem_d = ctrl_i.last ? '0 : acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign parity_error_o = |acc;
  assign rem_zero_o     = ~|rem_q;

endmodule

`default_nettype wire

@@ rtl/core/bch_syndrome_byte_checker.sv @@
// Byte-serial parity checker for BCH codewords of the normal, short and
// medium frame codes. Codeword bytes arrive most significant bit first on the
// request channel (in_valid_i/in_ready_o with data_byte_i and last_byte_i).
// Each byte is divided into a remainder register by the generator of the
// mode selected in the code_mode register, written through the APB port.
// On the byte flagged last, one request leaves on the result channel
// (out_valid_o/out_ready_i with parity_error_o) and the remainder clears.
// A byte is captured in an input register and divided from there; the result
// of a last byte is captured in the output register. One byte per cycle is
// sustained unless a last byte waits on a stalled receiver; the division is
// a single XOR network between the input and remainder registers.
// When the receiver stalls, a pending result is held in the output register
// and one more byte can wait in the input register; only a second last byte
// is then held back. Reset empties both registers, clears the remainder and
// selects the 192-bit normal code. Change code_mode only while idle.
`default_nettype none

module bch_syndrome_byte_checker
  import bsbc_pkg::*;
#(
  parameter int unsigned MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic                     last_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          parity_error_o
);

  code_mode_e mode;
  rem_ctrl_t  ctrl;
  logic       err_next;
  logic       rem_zero;
  logic       advance;

  logic       in_valid_q;
  logic       in_valid_d;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_err_q;

  bsbc_cfg #(
    .MAX_PARITY_BITS(MAX_PARITY_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .mode_o (mode)
  );

  assign advance = in_valid_q && (!in_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign ctrl.advance = advance;
  assign ctrl.last    = in_last_q;

  bsbc_rem #(
    .MAX_PARITY_BITS(MAX_PARITY_BITS)
  ) u_rem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .data_byte_i   (in_data_q),
    .mode_i        (mode),
    .parity_error_o(err_next),
    .rem_zero_o    (rem_zero)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (advance && in_last_q) begin
      out_err_q <= err_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parity_error_o = out_err_q;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> out_valid_o)
    else $error("last byte produced no result");

  a_last_clears_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> rem_zero)
    else $error("remainder not cleared after last byte");

  a_stall_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_last_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");
`endif

endmodule

`default_nettype wire

@@ verif/tb_bch_syndrome_byte_checker.sv @@
`default_nettype none

module tb_bch_syndrome_byte_checker;
  import bsbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REM_BITS = 192;
  localparam int PROD_BITS = 224;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_BYTES = 1250;
  localparam int TARGET_WORDS = 48;
  localparam logic [MODE_BITS-1:0] MODE_UNDEF_TOP = '1;

  localparam logic [16:0] BCH_MINPOLY [3][12] = '{
    '{17'h1002D, 17'h10173, 17'h10FBD, 17'h15A55, 17'h11F2F, 17'h1F7B5,
      17'h1AF65, 17'h17367, 17'h10EA1, 17'h175A7, 17'h13A2D, 17'h11AE3},
    '{17'h0402B, 17'h04941, 17'h04647, 17'h05591, 17'h06B55, 17'h06389,
      17'h06CE5, 17'h04F21, 17'h0460F, 17'h05A49, 17'h05811, 17'h065EF},
    '{17'h0802D, 17'h08C93, 17'h0B555, 17'h08D6D, 17'h094D7, 17'h0B0D1,
      17'h0D8B5, 17'h0CB55, 17'h0BAB7, 17'h0BC9F, 17'h08A17, 17'h0ED15}
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
  } cw_byte_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               data_byte_i = '0;
  logic                     last_byte_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     parity_error_o;

  cw_byte_t             byte_q[$];
  bit                   parity_exp_q[$];
  logic [REM_BITS-1:0]  gen_tab [5];
  logic [REM_BITS-1:0]  pred_rem = '0;
  logic [MODE_BITS-1:0] pred_mode = MODE_N12;
  int idle_pct = 12;
  int fails = 0;
  int cycle_count = 0;
  int bytes_queued = 0;
  int words_queued = 0;
  int bytes_taken = 0;
  int clean_words = 0;
  int flagged_words = 0;
  int mode_writes = 0;

  bch_syndrome_byte_checker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parity_error_o (parity_error_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int code_width(input code_mode_e m);
    case (m)
      MODE_N8:     return 128;
      MODE_N10:    return 160;
      MODE_SHORT:  return 168;
      MODE_MEDIUM: return 180;
      default:     return 192;
    endcase
  endfunction

  function automatic code_mode_e effective_mode(input logic [MODE_BITS-1:0] raw);
    code_mode_e m;
    if (raw > MODE_MEDIUM) begin
      m = MODE_N12;
    end else begin
      m = code_mode_e'(raw);
    end
    if (code_width(m) > MAX_PARITY_BITS_DEF) begin
      m = MODE_N8;
    end
    return m;
  endfunction

  function automatic logic [REM_BITS-1:0] make_generator(input code_mode_e m);
    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] nxt;
    logic [REM_BITS-1:0]  g;
    int row;
    int terms;
    int w;
    case (m)
      MODE_SHORT:  row = 1;
      MODE_MEDIUM: row = 2;
      default:     row = 0;
    endcase
    case (m)
      MODE_N8:  terms = 8;
      MODE_N10: terms = 10;
      default:  terms = 12;
    endcase
    w = code_width(m);
    prod = PROD_BITS'(1);
    for (int p = 0; p < terms; p++) begin
      nxt = '0;
      for (int i = 0; i <= REM_BITS; i++) begin
        if (prod[i]) begin
          nxt = nxt ^ (PROD_BITS'(BCH_MINPOLY[row][p]) << i);
        end
      end
      prod = nxt;
    end
    g = '0;
    for (int k = 0; k < w; k++) begin
      g[REM_BITS-1-k] = prod[w-1-k];
    end
    return g;
  endfunction

  function automatic logic [REM_BITS-1:0] shift_bit(input logic [REM_BITS-1:0] r,
                                                    input logic b,
                                                    input logic [REM_BITS-1:0] g);
    logic fb;
    fb = r[REM_BITS-1] ^ b;
    r = r << 1;
    if (fb) begin
      r = r ^ g;
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] d, input logic last);
    logic [REM_BITS-1:0] g;
    g = gen_tab[effective_mode(pred_mode)];
    for (int b = 7; b >= 0; b--) begin
      pred_rem = shift_bit(pred_rem, d[b], g);
    end
    bytes_taken++;
    if (last) begin
      parity_exp_q.push_back(pred_rem != '0);
      pred_rem = '0;
    end
  endtask

  always @(posedge clk_i) begin
    cw_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_byte(data_byte_i, last_byte_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    bit want_err;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parity_exp_q.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual parity_error=%0b",
                 $time, parity_error_o);
        fails++;
      end else begin
        want_err = parity_exp_q.pop_front();
        if (parity_error_o !== want_err) begin
          $display("%0t: parity_error mismatch: expected %0b, actual %0b",
                   $time, want_err, parity_error_o);
          fails++;
        end
        if (want_err) begin
          flagged_words++;
        end else begin
          clean_words++;
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic last);
    cw_byte_t item;
    item.data = d;
    item.last = last;
    byte_q.push_back(item);
    bytes_queued++;
    if (last) begin
      words_queued++;
    end
  endtask

  task automatic queue_codeword(input int msg_bytes, input bit corrupt);
    code_mode_e m;
    logic [REM_BITS-1:0] g;
    logic [REM_BITS-1:0] r;
    logic [7:0] d;
    bit bits[$];
    bit b;
    int w;
    int nmsg;
    int idx;
    m = effective_mode(pred_mode);
    g = gen_tab[m];
    w = code_width(m);
    r = '0;
    nmsg = msg_bytes * 8 + (8 - w % 8) % 8;
    for (int i = 0; i < nmsg; i++) begin
      b = $urandom_range(1);
      bits.push_back(b);
      r = shift_bit(r, b, g);
    end
    for (int k = 0; k < w; k++) begin
      bits.push_back(r[REM_BITS-1-k]);
    end
    if (corrupt) begin
      idx = $urandom_range(bits.size() - 1);
      bits[idx] = !bits[idx];
    end
    for (int n = 0; n < bits.size() / 8; n++) begin
      for (int j = 0; j < 8; j++) begin
        d[7-j] = bits[n*8+j];
      end
      push_byte(d, n == bits.size() / 8 - 1);
    end
  endtask

  task automatic queue_noise(input bit force_last);
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom()), (i == n - 1) ? force_last : ($urandom_range(3) == 0));
    end
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || in_valid_i || parity_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_access(input reg_index_e idx, input logic wr,
                            input logic [APB_DATA_BITS-1:0] word,
                            output logic [APB_DATA_BITS-1:0] rd);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input reg_index_e idx, input logic [MODE_BITS-1:0] mode);
    logic [APB_DATA_BITS-1:0] word;
    logic [APB_DATA_BITS-1:0] rd;
    word = $urandom();
    word[MODE_BITS-1:0] = mode;
    cfg_access(idx, 1'b1, word, rd);
    if (idx == REG_CODE_MODE) begin
      pred_mode = mode;
      mode_writes++;
    end
    cfg_access(REG_CODE_MODE, 1'b0, '0, rd);
    if (rd !== APB_DATA_BITS'(pred_mode)) begin
      $display("%0t: code_mode readback mismatch: expected %0h, actual %0h",
               $time, APB_DATA_BITS'(pred_mode), rd);
      fails++;
    end
  endtask

  initial begin
    int phase;
    int pick;
    logic [MODE_BITS-1:0] mode;
    logic [APB_DATA_BITS-1:0] rd;
    for (int m = 0; m <= int'(MODE_MEDIUM); m++) begin
      gen_tab[m] = make_generator(code_mode_e'(m));
    end
    pred_mode = MODE_N12;
    pred_rem = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_access(REG_CODE_MODE, 1'b0, '0, rd);
    if (rd !== APB_DATA_BITS'(MODE_N12)) begin
      $display("%0t: code_mode after reset: expected %0h, actual %0h",
               $time, APB_DATA_BITS'(MODE_N12), rd);
      fails++;
    end
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();
    cfg_write(REG_UNUSED, MODE_N8);
    push_byte(8'h80, 1'b1);
    settle();
    cfg_write(REG_CODE_MODE, MODE_MEDIUM);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h01, 1'b0);
    settle();
    // The remainder survives a mode change in the middle of a codeword.
    cfg_write(REG_CODE_MODE, MODE_N8);
    push_byte(8'hFF, 1'b1);
    settle();
    cfg_write(REG_CODE_MODE, MODE_UNDEF_TOP);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h7E, 1'b1);
    settle();
    cfg_write(REG_CODE_MODE, MODE_N10);
    push_byte(8'h3C, 1'b1);
    settle();

    phase = 0;
    while (bytes_queued < TARGET_BYTES || words_queued < TARGET_WORDS) begin
      case (phase)
        0:       mode = MODE_N8;
        1:       mode = MODE_MEDIUM;
        2:       mode = MODE_UNDEF_TOP;
        3:       mode = MODE_SHORT;
        default: mode = MODE_BITS'($urandom_range(7));
      endcase
      if ($urandom_range(4) == 0) begin
        cfg_write(REG_UNUSED, MODE_BITS'($urandom_range(7)));
      end
      cfg_write(REG_CODE_MODE, mode);
      idle_pct = (phase == 4) ? 0 : 12;
      repeat (6) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          queue_codeword(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6),
                         1'b0);
        end else if (pick < 85) begin
          queue_codeword($urandom_range(6), 1'b1);
        end else if (pick < 95) begin
          queue_noise(1'b1);
        end else begin
          queue_noise(1'b0);
        end
      end
      settle();
      phase++;
    end

    idle_pct = 12;
    settle();
    $display("Checked %0d codewords (%0d clean, %0d flagged) from %0d bytes.",
             clean_words + flagged_words, clean_words, flagged_words, bytes_taken);
    $display("Used %0d code mode settings over %0d phases, undefined modes included.",
             mode_writes, phase);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/bsbc_pkg.sv
rtl/core/bsbc_cfg.sv
rtl/core/bsbc_rem.sv
rtl/core/bch_syndrome_byte_checker.sv
verif/tb_bch_syndrome_byte_checker.sv
